// ===== rtl/core/mail_body_relaxed_canon_unit_macros.svh =====
// Assertion macros for the relaxed body canonicalization unit.
// Each macro expands to one labeled concurrent assertion that is disabled
// while reset is high.
`ifndef MAIL_BODY_RELAXED_CANON_UNIT_MACROS_SVH
`define MAIL_BODY_RELAXED_CANON_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbrc assertion failed");

// The condition must never be true.
`define MBRC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("mbrc assertion failed");

`endif

// ===== rtl/core/mbrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_pkg
// Types and constants shared by the relaxed body canonicalization unit.
// ----------------------------------------------------------------------------
package mbrc_pkg;

   localparam int LINE_COUNT_BITS_DEFAULT = 16;
   localparam int TOKEN_VALUE_W           = 16;
   localparam int QUEUE_DEPTH             = 4;

   // Token kinds.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_CRLF = 1'b1;

   // Body characters.
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   // Token slots of one bundle, in emission order.
   localparam int SLOT_CRLF  = 0;
   localparam int SLOT_SPACE = 1;
   localparam int SLOT_CR    = 2;
   localparam int SLOT_BYTE  = 3;
   localparam int SLOT_FINAL = 4;
   localparam int SLOT_COUNT = 5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_body;
   } req_type;

   typedef struct packed {
      logic                     token_kind;
      logic [TOKEN_VALUE_W-1:0] token_value;
      logic                     token_last;
   } rsp_type;

   // All tokens that one item causes, with a mask of which are present.
   typedef struct packed {
      logic [SLOT_COUNT-1:0]    mask;
      logic [TOKEN_VALUE_W-1:0] crlf_count;
      logic [7:0]               data_byte;
   } bundle_type;

   // Queue head as seen by the back part.
   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } queue_head_type;

endpackage

// ===== rtl/core/mbrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_front
// Classifies each body byte, keeps the line state and builds the token bundle.
// ----------------------------------------------------------------------------
module mbrc_front #(
   parameter int LINE_COUNT_BITS = mbrc_pkg::LINE_COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  mbrc_pkg::req_type    req_payload,
   input  logic                 queue_full,
   output logic                 req_stall,
   output logic                 push,
   output mbrc_pkg::bundle_type push_bundle
);

   // Saturation limit is min(2^LINE_COUNT_BITS - 1, 65535).
   localparam logic [LINE_COUNT_BITS-1:0] CountLimit = LINE_COUNT_BITS'(32'h0000FFFF);

   logic [LINE_COUNT_BITS-1:0] line_ends_ff, line_ends_in;
   logic                       space_ff, space_in;
   logic                       held_cr_ff, held_cr_in;

   logic accept;
   logic is_lf, is_cr, is_blank, is_content, release_all;
   logic [31:0] line_ends_wide;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign is_lf      = req_payload.data_byte == mbrc_pkg::CHAR_LF;
   assign is_cr      = req_payload.data_byte == mbrc_pkg::CHAR_CR;
   assign is_blank   = (req_payload.data_byte == mbrc_pkg::CHAR_SPACE) ||
                       (req_payload.data_byte == mbrc_pkg::CHAR_TAB);
   assign is_content = !is_lf && !is_cr && !is_blank;

   // A held CR turns into content when anything but LF follows it.
   assign release_all = req_payload.has_byte &&
                        (is_content || ((is_cr || is_blank) && held_cr_ff));

   assign line_ends_wide = 32'(line_ends_ff);

   always_comb begin
      push_bundle = '0;
      push_bundle.mask[mbrc_pkg::SLOT_CRLF]  = release_all && (line_ends_ff != '0);
      push_bundle.mask[mbrc_pkg::SLOT_SPACE] = release_all && space_ff;
      push_bundle.mask[mbrc_pkg::SLOT_CR]    = release_all && held_cr_ff;
      push_bundle.mask[mbrc_pkg::SLOT_BYTE]  = req_payload.has_byte && is_content;
      push_bundle.mask[mbrc_pkg::SLOT_FINAL] = req_payload.end_of_body;
      push_bundle.crlf_count = line_ends_wide[mbrc_pkg::TOKEN_VALUE_W-1:0];
      push_bundle.data_byte  = req_payload.data_byte;
   end

   assign push = accept && (push_bundle.mask != '0);

   always_comb begin
      line_ends_in = line_ends_ff;
      space_in     = space_ff;
      held_cr_in   = held_cr_ff;
      if (release_all) begin
         line_ends_in = '0;
         space_in     = 1'b0;
         held_cr_in   = 1'b0;
      end
      if (req_payload.has_byte) begin
         if (is_lf) begin
            held_cr_in = 1'b0;
            space_in   = 1'b0;
            if (line_ends_ff < CountLimit) begin
               line_ends_in = line_ends_ff + 1'b1;
            end
         end else if (is_cr) begin
            held_cr_in = 1'b1;
         end else if (is_blank) begin
            space_in = 1'b1;
         end
      end
      if (req_payload.end_of_body) begin
         line_ends_in = '0;
         space_in     = 1'b0;
         held_cr_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ends_ff <= '0;
         space_ff     <= 1'b0;
         held_cr_ff   <= 1'b0;
      end else if (accept) begin
         line_ends_ff <= line_ends_in;
         space_ff     <= space_in;
         held_cr_ff   <= held_cr_in;
      end
   end

endmodule

// ===== rtl/core/mbrc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_queue
// Short queue of token bundles between the front and back parts.
// ----------------------------------------------------------------------------
module mbrc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mbrc_pkg::bundle_type     push_bundle,
   input  logic                     pop,
   output mbrc_pkg::queue_head_type head,
   output logic                     full
);

   localparam int Depth = mbrc_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   mbrc_pkg::bundle_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      if (p == PtrW'(Depth - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full          = count_ff == CntW'(Depth);
   assign head.valid    = count_ff != '0;
   assign head.bundle   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/mbrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_back
// Unpacks token bundles into single tokens and drives the output register.
// ----------------------------------------------------------------------------
module mbrc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mbrc_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   output mbrc_pkg::rsp_type        rsp_payload,
   input  logic                     rsp_stall
);

   logic [mbrc_pkg::SLOT_COUNT-1:0] cur_mask_ff, cur_mask_in;
   mbrc_pkg::bundle_type            cur_ff;
   logic                            rsp_valid_ff;
   mbrc_pkg::rsp_type               rsp_ff, rsp_in;

   logic                            slot_free, use_cur, emit;
   mbrc_pkg::bundle_type            act;
   logic [mbrc_pkg::SLOT_COUNT-1:0] act_mask, sel;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign use_cur   = cur_mask_ff != '0;
   assign act       = use_cur ? cur_ff : head.bundle;
   assign act_mask  = use_cur ? cur_mask_ff :
                      (head.valid ? head.bundle.mask : '0);
   // Lowest set bit is the next token in emission order.
   assign sel       = act_mask & (~act_mask + 1'b1);
   assign emit      = slot_free && (act_mask != '0);
   assign pop       = emit && !use_cur;

   assign cur_mask_in = emit ? (act_mask & ~sel) : cur_mask_ff;

   always_comb begin
      rsp_in             = '0;
      rsp_in.token_kind  = mbrc_pkg::KIND_BYTE;
      if (sel[mbrc_pkg::SLOT_CRLF]) begin
         rsp_in.token_kind  = mbrc_pkg::KIND_CRLF;
         rsp_in.token_value = act.crlf_count;
      end else if (sel[mbrc_pkg::SLOT_SPACE]) begin
         rsp_in.token_value = mbrc_pkg::TOKEN_VALUE_W'(mbrc_pkg::CHAR_SPACE);
      end else if (sel[mbrc_pkg::SLOT_CR]) begin
         rsp_in.token_value = mbrc_pkg::TOKEN_VALUE_W'(mbrc_pkg::CHAR_CR);
      end else if (sel[mbrc_pkg::SLOT_BYTE]) begin
         rsp_in.token_value = mbrc_pkg::TOKEN_VALUE_W'(act.data_byte);
      end else begin
         rsp_in.token_kind  = mbrc_pkg::KIND_CRLF;
         rsp_in.token_value = mbrc_pkg::TOKEN_VALUE_W'(1);
         rsp_in.token_last  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head.bundle;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_mask_ff <= cur_mask_in;
         if (slot_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/mail_body_relaxed_canon_unit.sv =====
`timescale 1ns / 1ps
// The first token of an item is held in a queue entry, then in the output register.
// One item per cycle while each causes at most one token and no stall occurs;
// the sequencer sends one token per cycle unless stalled; big items hold it longer.
// A four-entry bundle queue absorbs such bursts before the input stalls.
// Reset (synchronous) clears the line state, the queue and the output register.
// ----------------------------------------------------------------------------
// mail_body_relaxed_canon_unit
// Relaxed body canonicalization: body bytes in, data and CRLF-run tokens out.
// ----------------------------------------------------------------------------
`include "mail_body_relaxed_canon_unit_macros.svh"

module mail_body_relaxed_canon_unit #(
   parameter int LINE_COUNT_BITS = mbrc_pkg::LINE_COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  mbrc_pkg::req_type req_payload,
   output logic              req_stall,
   output logic              rsp_valid,
   output mbrc_pkg::rsp_type rsp_payload,
   input  logic              rsp_stall
);

   logic                     q_push, q_pop, q_full;
   mbrc_pkg::bundle_type     q_push_bundle;
   mbrc_pkg::queue_head_type q_head;

   mbrc_front #(
      .LINE_COUNT_BITS(LINE_COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_payload(req_payload),
      .queue_full (q_full),
      .req_stall  (req_stall),
      .push       (q_push),
      .push_bundle(q_push_bundle)
   );

   mbrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_bundle(q_push_bundle),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full)
   );

   mbrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall  (rsp_stall)
   );

   `MBRC_ASSERT_NEVER(a_push_when_full, clock, reset, q_push && q_full)
   `MBRC_ASSERT_IMPLY(a_pop_needs_entry, clock, reset, q_pop, q_head.valid)
   `MBRC_ASSERT_NEVER(a_full_and_empty, clock, reset, q_full && !q_head.valid)
   `MBRC_ASSERT_IMPLY(a_last_is_final_crlf, clock, reset, rsp_valid && rsp_payload.token_last, rsp_payload.token_kind == mbrc_pkg::KIND_CRLF && rsp_payload.token_value == 16'd1)

endmodule

// ===== test/tb_mail_body_relaxed_canon_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mail_body_relaxed_canon_unit
// Self-checking bench for the relaxed body canonicalization unit.
// A queue of body items feeds a bursty driver. Each accepted item runs
// through a local line-state predictor that queues the tokens it should
// produce. A monitor pops and compares every token the unit sends, while the
// receiver stalls on its own changing pattern and holds off for long
// stretches twice. The stimulus covers hand-picked bodies, a long run of
// line ends, and random well-formed bodies mixed with raw noise items.
// ----------------------------------------------------------------------------
module tb_mail_body_relaxed_canon_unit;

   localparam int LINE_BITS = mbrc_pkg::LINE_COUNT_BITS_DEFAULT;
   localparam int VALUE_W   = mbrc_pkg::TOKEN_VALUE_W;
   localparam logic [VALUE_W-1:0] LINE_LIMIT =
      (LINE_BITS >= VALUE_W) ? {VALUE_W{1'b1}} :
                               VALUE_W'((64'd1 << LINE_BITS) - 1);
   localparam int RANDOM_ITEMS = 340;
   localparam int LF_RUN_ITEMS = 40;
   localparam int LONG_HOLD_CYCLES = 150;

   typedef struct {
      mbrc_pkg::req_type item;
      bit                wait_drain;
   } body_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   mbrc_pkg::req_type req_payload = '0;
   logic              req_stall;
   logic              rsp_valid;
   mbrc_pkg::rsp_type rsp_payload;
   logic              rsp_stall = 1'b0;

   body_entry_type    body_items[$];
   mbrc_pkg::rsp_type expected_tokens[$];

   // Predicted line state.
   logic [VALUE_W-1:0] lf_count = '0;
   bit                 blank_held = 0;
   bit                 cr_held = 0;

   int error_count = 0;
   int tokens_checked = 0;
   int items_accepted = 0;
   int bodies_done = 0;
   int longest_run = 0;
   int hold_at[2];
   int holds_done = 0;

   mail_body_relaxed_canon_unit #(
      .LINE_COUNT_BITS(LINE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_payload(req_payload),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall  (rsp_stall)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic push_token(input logic kind, input logic [VALUE_W-1:0] value,
                             input logic last);
      mbrc_pkg::rsp_type tok;
      tok.token_kind  = kind;
      tok.token_value = value;
      tok.token_last  = last;
      expected_tokens.insert(expected_tokens.size(), tok);
   endtask

   // Line ends, then the blank, then a held CR go out ahead of content.
   task automatic release_held();
      if (lf_count != 0) begin
         push_token(mbrc_pkg::KIND_CRLF, lf_count, 1'b0);
         if (int'(lf_count) > longest_run) longest_run = int'(lf_count);
      end
      lf_count = '0;
      if (blank_held) begin
         push_token(mbrc_pkg::KIND_BYTE, VALUE_W'(mbrc_pkg::CHAR_SPACE), 1'b0);
      end
      blank_held = 0;
      if (cr_held) push_token(mbrc_pkg::KIND_BYTE, VALUE_W'(mbrc_pkg::CHAR_CR), 1'b0);
      cr_held = 0;
   endtask

   task automatic predict_tokens(input mbrc_pkg::req_type item);
      if (item.has_byte) begin
         if (item.data_byte == mbrc_pkg::CHAR_LF) begin
            cr_held    = 0;
            blank_held = 0;
            if (lf_count < LINE_LIMIT) lf_count = lf_count + 1'b1;
         end else if (item.data_byte == mbrc_pkg::CHAR_CR) begin
            if (cr_held) release_held();
            cr_held = 1;
         end else if (item.data_byte == mbrc_pkg::CHAR_SPACE ||
                      item.data_byte == mbrc_pkg::CHAR_TAB) begin
            if (cr_held) release_held();
            blank_held = 1;
         end else begin
            release_held();
            push_token(mbrc_pkg::KIND_BYTE, VALUE_W'(item.data_byte), 1'b0);
         end
      end
      if (item.end_of_body) begin
         push_token(mbrc_pkg::KIND_CRLF, VALUE_W'(1), 1'b1);
         lf_count   = '0;
         blank_held = 0;
         cr_held    = 0;
         bodies_done++;
      end
   endtask

   task automatic queue_item(input logic [7:0] b, input logic has, input logic eob,
                             input bit drain);
      body_entry_type e;
      e.item.data_byte   = b;
      e.item.has_byte    = has;
      e.item.end_of_body = eob;
      e.wait_drain       = drain;
      body_items.insert(body_items.size(), e);
   endtask

   task automatic queue_random_body(input bit drain);
      int lines;
      int parts;
      int len;
      bit first;
      first = drain;
      lines = $urandom_range(0, 5);
      for (int l = 0; l < lines; l++) begin
         parts = $urandom_range(0, 5);
         for (int p = 0; p < parts; p++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  len = $urandom_range(1, 5);
                  for (int k = 0; k < len; k++) begin
                     queue_item(8'($urandom_range(33, 126)), 1'b1, 1'b0, first);
                     first = 0;
                  end
               end
               4, 5: begin
                  len = $urandom_range(1, 3);
                  for (int k = 0; k < len; k++) begin
                     queue_item($urandom_range(0, 1) ? mbrc_pkg::CHAR_SPACE :
                                                       mbrc_pkg::CHAR_TAB,
                                1'b1, 1'b0, first);
                     first = 0;
                  end
               end
               6: queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, first);
               7: queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, first);
               8: queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, first);
               default: begin
                  queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, first);
                  queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, 0);
               end
            endcase
            first = 0;
         end
         case ($urandom_range(0, 5))
            0, 1, 2: begin
               queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, first);
               queue_item(mbrc_pkg::CHAR_LF, 1'b1, 1'b0, 0);
            end
            3, 4: queue_item(mbrc_pkg::CHAR_LF, 1'b1, 1'b0, first);
            default: ;
         endcase
         first = 0;
         if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) queue_item(mbrc_pkg::CHAR_LF, 1'b1, 1'b0, 0);
         end
      end
      queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, first);
   endtask

   // Driver: bursts of random length separated by random gaps.
   int burst_left = 8;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_tokens(req_payload);
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (body_items.size() == 0 ||
                         (body_items[0].wait_drain && expected_tokens.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_payload <= body_items[0].item;
               req_valid   <= 1'b1;
               void'(body_items.pop_front());
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Receiver stall pattern, with two long hold-offs that back the unit up.
   int hold_left = 0;
   int mode_left = 0;
   int stall_mode = 0;
   int stall_tick = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_tick++;
         if (hold_left == 0 && holds_done < 2 && items_accepted >= hold_at[holds_done]) begin
            hold_left = LONG_HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= (stall_tick % 3 == 0);
            endcase
         end
      end
   end

   // Monitor: every accepted token is matched against the oldest prediction.
   always @(posedge clock) begin : token_monitor
      mbrc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token kind %0d value %0d last %0d", $time,
                     rsp_payload.token_kind, rsp_payload.token_value, rsp_payload.token_last);
            error_count++;
         end else begin
            want = expected_tokens.pop_front();
            tokens_checked++;
            if (rsp_payload.token_kind !== want.token_kind ||
                rsp_payload.token_value !== want.token_value ||
                rsp_payload.token_last !== want.token_last) begin
               $display("%0t: expected kind %0d value %0d last %0d, got %0d %0d %0d",
                        $time, want.token_kind, want.token_value, want.token_last,
                        rsp_payload.token_kind, rsp_payload.token_value,
                        rsp_payload.token_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      int base_count;

      // Empty body, then the byte extremes.
      queue_item(8'h00, 1'b0, 1'b1, 0);
      queue_item(8'h00, 1'b1, 1'b0, 0);
      queue_item(8'hFF, 1'b1, 1'b0, 0);
      // A blank run inside a line shrinks to one space.
      queue_item("a", 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_SPACE, 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_TAB, 1'b1, 1'b0, 0);
      queue_item("b", 1'b1, 1'b0, 0);
      // A CR before content is content.
      queue_item("c", 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, 0);
      queue_item("x", 1'b1, 1'b0, 0);
      // Two CRs then LF: the first CR is released, the second joins the line end.
      queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_LF, 1'b1, 1'b0, 0);
      // Trailing blanks vanish and line ends go out as one run.
      queue_item(mbrc_pkg::CHAR_SPACE, 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_LF, 1'b1, 1'b0, 0);
      queue_item("d", 1'b1, 1'b0, 0);
      // A blank after a held CR releases it; the last item carries a byte.
      queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_SPACE, 1'b1, 1'b0, 0);
      queue_item("e", 1'b1, 1'b1, 0);
      // Everything still held at the end of a body is dropped.
      queue_item(mbrc_pkg::CHAR_LF, 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_LF, 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_SPACE, 1'b1, 1'b0, 0);
      queue_item(mbrc_pkg::CHAR_CR, 1'b1, 1'b0, 0);
      queue_item(8'h0A, 1'b0, 1'b1, 0);

      // A long run of line ends goes out as a single token.
      for (int i = 0; i < LF_RUN_ITEMS; i++) begin
         queue_item(mbrc_pkg::CHAR_LF, 1'b1, 1'b0, i == 0);
      end
      queue_item("Z", 1'b1, 1'b1, 0);

      base_count = body_items.size();
      while (body_items.size() < base_count + RANDOM_ITEMS) begin
         queue_random_body($urandom_range(0, 11) == 0);
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 8))
               queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 0);
         end
      end
      hold_at[0] = body_items.size() / 6;
      hold_at[1] = (body_items.size() * 2) / 3;

      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (body_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         $display("%0t: %0d predicted tokens never arrived", $time, expected_tokens.size());
         error_count++;
      end

      $display("Sent %0d items over %0d bodies and checked %0d tokens.",
               items_accepted, bodies_done, tokens_checked);
      $display("Longest line end run released: %0d.", longest_run);
      if (error_count == 0) begin
         $display("[mail_body_relaxed_canon_unit] OK");
      end else begin
         $display("[mail_body_relaxed_canon_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Timed out with %0d items and %0d tokens outstanding.", body_items.size(),
               expected_tokens.size());
      $display("[mail_body_relaxed_canon_unit] ERROR");
      $finish;
   end

endmodule
